>>> rtl/core/mhe_pkg.sv
// Package for the multiband histogram engine.
// Holds the action and register codes, payload widths and the result type.
// No dependencies.
`default_nettype none

package mhe_pkg;

	// Fixed field widths of the channels
	localparam int ACTION_W   = 2;
	localparam int SAMPLE_W   = 16;
	localparam int BAND_W     = 2;
	localparam int COUNT_W    = 32;
	localparam int LENGTH_W   = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	// Result queue
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = 2;

	// Histogram length reported for eight-bit samples
	localparam logic [LENGTH_W-1:0] NARROW_LENGTH = 17'd256;

	// band_choice code that selects every band
	localparam logic [CFG_DATA_W-1:0] CHOICE_ALL = 3'b111;

	typedef enum logic [ACTION_W-1:0] {
		ACT_COUNT = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAND_COUNT   = 2'd0,
		REG_BAND_CHOICE  = 2'd1,
		REG_WIDE_SAMPLES = 2'd2
	} reg_idx_e;

	typedef struct packed {
		logic [COUNT_W-1:0]  bin_count;
		logic [LENGTH_W-1:0] hist_length;
		logic                beyond_length;
	} result_t;

	// Result handed from the pipeline to the result queue
	typedef struct packed {
		logic    vld;
		result_t data;
	} push_t;

endpackage

`default_nettype wire

>>> rtl/core/mhe_cfg_if.sv
// Configuration write channel of the multiband histogram engine.
// Depends on mhe_pkg for the index and data widths.
`default_nettype none

interface mhe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [mhe_pkg::CFG_IDX_W-1:0]    index;
	logic [mhe_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mhe_req_if.sv
// Request channel (count, read, clear) of the multiband histogram engine.
// Depends on mhe_pkg for the field widths.
`default_nettype none

interface mhe_req_if;
	logic                           valid;
	logic                           ready;
	logic [mhe_pkg::ACTION_W-1:0]   action;
	logic [mhe_pkg::SAMPLE_W-1:0]   sample_value;
	logic [mhe_pkg::SAMPLE_W-1:0]   bin_index;
	logic [mhe_pkg::BAND_W-1:0]     band_index;

	modport source (output valid, output action, output sample_value, output bin_index,
		output band_index, input ready);
	modport sink   (input valid, input action, input sample_value, input bin_index,
		input band_index, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mhe_rsp_if.sv
// Response channel carrying read results of the multiband histogram engine.
// Depends on mhe_pkg for the field widths.
`default_nettype none

interface mhe_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mhe_pkg::COUNT_W-1:0]    bin_count;
	logic [mhe_pkg::LENGTH_W-1:0]   hist_length;
	logic                           beyond_length;

	modport source (output valid, output bin_count, output hist_length,
		output beyond_length, input ready);
	modport sink   (input valid, input bin_count, input hist_length,
		input beyond_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mhe_result_fifo.sv
// Three-entry result queue that decouples read results from the response channel.
// Depends on mhe_pkg and mhe_rsp_if.
`default_nettype none

module mhe_result_fifo (
	input  wire                          clk,
	input  wire                          arst_n,
	input  mhe_pkg::push_t               push,
	output logic [mhe_pkg::FIFO_PTR_W-1:0] level,
	mhe_rsp_if.source                    rsp
);

	mhe_pkg::result_t                entry_q [mhe_pkg::FIFO_DEPTH];
	logic [mhe_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [mhe_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [mhe_pkg::FIFO_PTR_W-1:0]  level_q;
	logic                            pop;
	mhe_pkg::result_t                head;

	assign pop   = rsp.valid && rsp.ready;
	assign level = level_q;
	assign head  = entry_q[rd_ptr_q];

	// Head of queue drives the channel
	assign rsp.valid         = (level_q != '0);
	assign rsp.bin_count     = head.bin_count;
	assign rsp.hist_length   = head.hist_length;
	assign rsp.beyond_length = head.beyond_length;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.vld) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push.vld) begin
				wr_ptr_q <= (wr_ptr_q == mhe_pkg::FIFO_PTR_W'(mhe_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mhe_pkg::FIFO_PTR_W'(mhe_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push.vld && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push.vld) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/multiband_histogram_engine.sv
// Top level of the multiband histogram engine: bin memory, read-modify-write pipeline,
// configuration registers. Depends on mhe_pkg, the three channel interfaces and
// mhe_result_fifo.
//
// The engine takes one request per cycle while no clearing pass runs and the queue has
// room: count a sample, read a bin, or clear. Counts are read-modify-write on a single
// bin memory of MAX_BANDS * 2^SAMPLE_BITS 32-bit words with a registered read; a write
// from the previous cycle is forwarded, so repeated bins count at full rate. A read
// result passes the stage-1 register and waits in a three-entry queue that drives the
// response channel. A clear, and the reset, start a pass that zeroes one word per cycle,
// during which no request is taken; configuration writes are taken at any time.
`default_nettype none

module multiband_histogram_engine #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_BANDS   = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	mhe_cfg_if.sink    cfg,
	mhe_req_if.sink    req,
	mhe_rsp_if.source  rsp
);

	localparam int DEPTH  = MAX_BANDS << SAMPLE_BITS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SET_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int CNT_W  = mhe_pkg::COUNT_W;
	localparam int LEN_W  = mhe_pkg::LENGTH_W;

	// Configuration registers
	logic [2:0]             band_count_q;
	logic [2:0]             band_choice_q;
	logic                   wide_q;

	// Histogram state outside the memory
	logic [SET_W-1:0]       pos_q;
	logic [SAMPLE_BITS-1:0] max_q;

	// Clearing pass
	logic                   clr_busy_q;
	logic [ADDR_W-1:0]      clr_addr_q;

	// Stage 1: memory data returns
	logic                   vld_s1;
	logic                   inc_s1;
	logic                   rd_s1;
	logic                   ok_s1;
	logic                   beyond_s1;
	logic [LEN_W-1:0]       len_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [CNT_W-1:0]       rd_data_s1;

	// Last write, for forwarding
	logic                   wr_vld_q;
	logic [ADDR_W-1:0]      wr_addr_q;
	logic [CNT_W-1:0]       wr_data_q;

	logic [CNT_W-1:0]       bins_mem [DEPTH];

	// Request decode
	logic                   accept;
	logic                   is_count;
	logic                   is_read;
	logic                   is_clear;
	logic [2:0]             nb;
	logic [SET_W-1:0]       pos_eff;
	logic [SET_W-1:0]       pos_next;
	logic                   choice_all;
	logic                   choice_ok;
	logic                   take;
	logic [SET_W-1:0]       set_sel;
	logic [SAMPLE_BITS-1:0] sample_v;
	logic [ADDR_W-1:0]      cnt_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      mem_addr;
	logic [LEN_W-1:0]       length;
	logic                   beyond;
	logic [2:0]             sets;
	logic                   band_ok;

	// Write side
	logic [CNT_W-1:0]       cur;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [CNT_W-1:0]       mem_wd;

	// Result queue hookup
	mhe_pkg::push_t                  push;
	logic [mhe_pkg::FIFO_PTR_W-1:0]  fifo_level;
	logic                            rd_pending;

	assign cfg.ready = 1'b1;

	// Request ready: no clearing pass, and queue room for every read in flight
	assign rd_pending = vld_s1 && rd_s1;
	assign req.ready  = !clr_busy_q &&
		((3'(fifo_level) + 3'(rd_pending)) <= 3'(mhe_pkg::FIFO_DEPTH - 1));
	assign accept     = req.valid && req.ready;

	always_comb begin
		is_count = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		case (req.action)
			mhe_pkg::ACT_COUNT: is_count = 1'b1;
			mhe_pkg::ACT_READ:  is_read  = 1'b1;
			mhe_pkg::ACT_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
	end

	// Bands in use: zero counts as one, saturate at MAX_BANDS
	always_comb begin
		if (band_count_q == '0) begin
			nb = 3'd1;
		end else if (int'(band_count_q) > MAX_BANDS) begin
			nb = 3'(MAX_BANDS);
		end else begin
			nb = band_count_q;
		end
	end

	// Band walk; a stale position after band_count shrinks restarts at zero
	assign pos_eff  = (4'(pos_q) >= 4'(nb)) ? '0 : pos_q;
	assign pos_next = ((4'(pos_eff) + 4'd1) >= 4'(nb)) ? '0 : SET_W'(pos_eff + 1'b1);

	// Band selection
	assign choice_all = (band_choice_q == mhe_pkg::CHOICE_ALL);
	assign choice_ok  = !band_choice_q[2] && (band_choice_q < nb);
	assign take       = choice_all || (choice_ok && (band_choice_q == 3'(pos_eff)));
	assign set_sel    = choice_all ? pos_eff : '0;

	// Sample masking and bin address
	assign sample_v = wide_q ? req.sample_value[SAMPLE_BITS-1:0] :
		SAMPLE_BITS'(req.sample_value[7:0]);
	assign cnt_addr = ADDR_W'({set_sel, sample_v});

	// Read checks
	assign length  = wide_q ? (LEN_W'(max_q) + LEN_W'(1)) : mhe_pkg::NARROW_LENGTH;
	assign beyond  = (LEN_W'(req.bin_index) >= length);
	assign sets    = choice_all ? nb : 3'd1;
	assign band_ok = (3'(req.band_index) < sets);
	assign rd_addr = ADDR_W'({SET_W'(req.band_index), req.bin_index[SAMPLE_BITS-1:0]});

	assign mem_addr = is_read ? rd_addr : cnt_addr;

	// Forward the write that landed on the edge of this stage's read
	assign cur = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_data_s1;

	// Write port: clearing pass or count increment
	assign mem_we = clr_busy_q || (vld_s1 && inc_s1);
	assign mem_wa = clr_busy_q ? clr_addr_q : addr_s1;
	assign mem_wd = clr_busy_q ? '0 : cur + CNT_W'(1);

	// Bin memory and forwarding copy
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1 <= bins_mem[mem_addr];
		end
		if (mem_we) begin
			bins_mem[mem_wa] <= mem_wd;
		end
		wr_addr_q <= mem_wa;
		wr_data_q <= mem_wd;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1   <= mem_addr;
			ok_s1     <= !beyond && band_ok;
			beyond_s1 <= beyond;
			len_s1    <= length;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q  <= 3'd1;
			band_choice_q <= mhe_pkg::CHOICE_ALL;
			wide_q        <= 1'b0;
			pos_q         <= '0;
			max_q         <= '0;
			clr_busy_q    <= 1'b1;
			clr_addr_q    <= '0;
			vld_s1        <= 1'b0;
			inc_s1        <= 1'b0;
			rd_s1         <= 1'b0;
			wr_vld_q      <= 1'b0;
		end else begin
			wr_vld_q <= mem_we;
			vld_s1   <= accept;
			inc_s1   <= accept && is_count && take;
			rd_s1    <= accept && is_read;

			// Configuration transaction
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					mhe_pkg::REG_BAND_COUNT:   band_count_q  <= cfg.data;
					mhe_pkg::REG_BAND_CHOICE:  band_choice_q <= cfg.data;
					mhe_pkg::REG_WIDE_SAMPLES: wide_q        <= cfg.data[0];
					default: ;
				endcase
			end

			if (clr_busy_q) begin
				// Zero one word per cycle
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end else if (accept && is_clear) begin
				clr_busy_q <= 1'b1;
				clr_addr_q <= '0;
				max_q      <= '0;
				pos_q      <= '0;
			end else if (accept && is_count) begin
				pos_q <= pos_next;
				if (take && wide_q && (sample_v > max_q)) begin
					max_q <= sample_v;
				end
			end
		end
	end

	// Read results into the queue
	assign push.vld                = rd_pending;
	assign push.data.bin_count     = ok_s1 ? cur : '0;
	assign push.data.hist_length   = len_s1;
	assign push.data.beyond_length = beyond_s1;

	mhe_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (fifo_level),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
